FILE: src/e2q_pkg.sv
// Package with shared types and constants for the Euler-to-quaternion block.
`timescale 1ns / 1ps
package e2q_pkg;
   localparam int WORK_FRAC = 30;
   localparam int TURN_UNITS = 46080;
   localparam int QUARTER_UNITS = 11520;
   localparam int EIGHTH_UNITS = 5760;
   localparam int ANGLE_TO_ACC = 8192;
   localparam longint INV_GAIN = 64'sd652032874;
   localparam int XY_WIDTH = 34;
   localparam int ACC_WIDTH = 34;
   localparam int MAX_STAGES = 32;

   typedef logic signed [XY_WIDTH-1:0] xy_type;
   typedef logic signed [ACC_WIDTH-1:0] acc_type;

   typedef struct packed {
      xy_type  x;
      xy_type  y;
      acc_type z;
   } rot_type;

   function automatic acc_type atan_deg(input int idx);
      acc_type r;
      r = '0;
      unique case (idx)
         0: r = 34'sd47185920;
         1: r = 34'sd27855475;
         2: r = 34'sd14718068;
         3: r = 34'sd7471121;
         4: r = 34'sd3750058;
         5: r = 34'sd1876857;
         6: r = 34'sd938658;
         7: r = 34'sd469357;
         8: r = 34'sd234682;
         9: r = 34'sd117342;
         10: r = 34'sd58671;
         11: r = 34'sd29335;
         12: r = 34'sd14668;
         13: r = 34'sd7334;
         14: r = 34'sd3667;
         15: r = 34'sd1833;
         16: r = 34'sd917;
         17: r = 34'sd458;
         18: r = 34'sd229;
         19: r = 34'sd115;
         20: r = 34'sd57;
         21: r = 34'sd29;
         22: r = 34'sd14;
         23: r = 34'sd7;
         24: r = 34'sd4;
         25: r = 34'sd2;
         26: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

FILE: src/e2q_if.sv
// Valid-ready channel interface carrying a payload word.
`timescale 1ns / 1ps
interface e2q_if #(parameter int WIDTH = 48) (input logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/e2q_cell.sv
// One CORDIC rotation cell for three angles, with a register at its output.
`timescale 1ns / 1ps
module e2q_cell #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                enable,
   input  e2q_pkg::rot_type    rot_in [3],
   output e2q_pkg::rot_type    rot_out [3]
);
   import e2q_pkg::*;

   rot_type rot_ff [3];
   rot_type rot_in_c [3];
   localparam acc_type ATAN = atan_deg(STAGE);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (rot_in[k].z >= 0) begin
            rot_in_c[k].x = rot_in[k].x - (rot_in[k].y >>> STAGE);
            rot_in_c[k].y = rot_in[k].y + (rot_in[k].x >>> STAGE);
            rot_in_c[k].z = rot_in[k].z - ATAN;
         end else begin
            rot_in_c[k].x = rot_in[k].x + (rot_in[k].y >>> STAGE);
            rot_in_c[k].y = rot_in[k].y - (rot_in[k].x >>> STAGE);
            rot_in_c[k].z = rot_in[k].z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff <= rot_in_c;
      end
   end

   assign rot_out = rot_ff;
endmodule

FILE: src/euler_to_quaternion.sv
// Top level: converts three Euler angles to a unit quaternion in a pipeline.
// Usage: angles arrive on the req channel as one word {angle_z_deg, angle_y_deg, angle_x_deg},
// each degrees times 64 in two's complement. The quaternion leaves on the rsp channel as
// {quat_w, quat_z, quat_y, quat_x}, Q1.OUT_FRAC_BITS, saturated to plus or minus 1.0.
// One word is taken every cycle while the pipeline advances. The pipeline registers, in
// order: angle reduction, octant fold, each CORDIC cell, the quadrant fix, the first and
// second multiplier levels, the sum and rounding, and the output register.
// The whole pipeline is a chain of valid bits with payload registers; it advances as one
// whenever the output register is empty or being taken, so a stalled receiver holds every
// stage and req_ready falls. Throughput is one word per cycle when rsp_ready stays high.
// Reset clears the valid bits only; no word is lost or duplicated across a stall.
// There is no configuration and no other state.
`timescale 1ns / 1ps
module euler_to_quaternion #(
   parameter int ANGLE_WIDTH = 16,
   parameter int OUT_FRAC_BITS = 14,
   parameter int TRIG_STAGES = 16
) (
   input logic clock,
   input logic reset,
   e2q_if.sink   req,
   e2q_if.source rsp
);
   import e2q_pkg::*;

   localparam int OUT_WIDTH = OUT_FRAC_BITS + 2;
   localparam int NSTAGE = TRIG_STAGES + 7;
   localparam int SH = WORK_FRAC - OUT_FRAC_BITS;
   localparam int RED_WIDTH = 34;
   localparam logic [RED_WIDTH-1:0] RED_BIAS = 34'd3019898880;
   localparam logic [14:0] RECIP_45 = 15'd23302;

   logic [NSTAGE-1:0] vld_ff;
   logic              advance;

   assign advance = !vld_ff[NSTAGE-1] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req.valid};
      end
   end

   // One turn is 45 * 1024 units and 4096 is 1 modulo 45, so the upper bits of the
   // biased angle fold into a small value whose remainder comes from a reciprocal.
   logic [15:0] turn_in [3];
   logic [15:0] turn_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [RED_WIDTH-1:0] u;
         logic [12:0]          t;
         logic [12:0]          t2;
         logic [27:0]          prod;
         logic [6:0]           quo;
         logic [5:0]           rem;
         u = RED_WIDTH'($signed(req.data[k*ANGLE_WIDTH +: ANGLE_WIDTH])) + RED_BIAS;
         t = {1'b0, u[21:10]} + {1'b0, u[33:22]};
         t2 = {1'b0, t[11:0]} + {12'd0, t[12]};
         prod = {15'd0, t2} * {13'd0, RECIP_45};
         quo = prod[26:20];
         rem = 6'(t2 - 13'(quo) * 13'd45);
         turn_in[k] = {rem, u[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         turn_ff <= turn_in;
      end
   end

   // Fold the reduced angle to a residual within one octant and a quadrant.
   rot_type    seed_in [3];
   rot_type    seed_ff [3];
   logic [1:0] quad_in [3];
   logic [1:0] quad_ff [TRIG_STAGES+1][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [17:0] h;
         logic [1:0]         q;
         h = $signed({2'b00, turn_ff[k]});
         q = 2'd0;
         for (int n = 0; n < 3; n++) begin
            if (h >= 18'(QUARTER_UNITS)) begin
               h = h - 18'(QUARTER_UNITS);
               q = q + 2'd1;
            end
         end
         if (h >= 18'(EIGHTH_UNITS)) begin
            h = h - 18'(QUARTER_UNITS);
            q = q + 2'd1;
         end
         seed_in[k].x = XY_WIDTH'(INV_GAIN);
         seed_in[k].y = '0;
         seed_in[k].z = ACC_WIDTH'(h) * ACC_WIDTH'(ANGLE_TO_ACC);
         quad_in[k] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seed_ff <= seed_in;
         quad_ff[0] <= quad_in;
         for (int g = 0; g < TRIG_STAGES; g++) begin
            quad_ff[g+1] <= quad_ff[g];
         end
      end
   end

   rot_type chain [TRIG_STAGES+1][3];
   assign chain[0] = seed_ff;

   for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
      e2q_cell #(.STAGE(g)) u_cell (
         .clock   (clock),
         .enable  (advance),
         .rot_in  (chain[g]),
         .rot_out (chain[g+1])
      );
   end

   // Clamp and quadrant swap.
   localparam logic signed [31:0] ONE = 32'sd1073741824;
   logic signed [31:0] c_ff [3];
   logic signed [31:0] s_ff [3];

   function automatic logic signed [31:0] clamp30(input xy_type v);
      if (v > XY_WIDTH'(ONE)) return ONE;
      if (v < -XY_WIDTH'(ONE)) return -ONE;
      return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            logic signed [31:0] cx;
            logic signed [31:0] sy;
            cx = clamp30(chain[TRIG_STAGES][k].x);
            sy = clamp30(chain[TRIG_STAGES][k].y);
            unique case (quad_ff[TRIG_STAGES][k])
               2'd1: begin c_ff[k] <= -sy; s_ff[k] <= cx; end
               2'd2: begin c_ff[k] <= -cx; s_ff[k] <= -sy; end
               2'd3: begin c_ff[k] <= sy; s_ff[k] <= -cx; end
               default: begin c_ff[k] <= cx; s_ff[k] <= sy; end
            endcase
         end
      end
   end

   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd536870912;
      return 32'(p >>> WORK_FRAC);
   endfunction

   // First multiplier level.
   logic signed [31:0] cxcy_ff, sxsy_ff, sxcy_ff, cxsy_ff, cz_ff, sz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cxcy_ff <= mulq(c_ff[0], c_ff[1]);
         sxsy_ff <= mulq(s_ff[0], s_ff[1]);
         sxcy_ff <= mulq(s_ff[0], c_ff[1]);
         cxsy_ff <= mulq(c_ff[0], s_ff[1]);
         cz_ff <= c_ff[2];
         sz_ff <= s_ff[2];
      end
   end

   // Second multiplier level.
   logic signed [31:0] p_ff [8];
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= mulq(sxcy_ff, cz_ff);
         p_ff[1] <= mulq(cxsy_ff, sz_ff);
         p_ff[2] <= mulq(cxsy_ff, cz_ff);
         p_ff[3] <= mulq(sxcy_ff, sz_ff);
         p_ff[4] <= mulq(cxcy_ff, sz_ff);
         p_ff[5] <= mulq(sxsy_ff, cz_ff);
         p_ff[6] <= mulq(cxcy_ff, cz_ff);
         p_ff[7] <= mulq(sxsy_ff, sz_ff);
      end
   end

   function automatic logic [OUT_WIDTH-1:0] finish(input logic signed [33:0] t);
      logic signed [33:0] r;
      logic signed [33:0] one;
      one = 34'sd1 <<< OUT_FRAC_BITS;
      r = (t + (34'sd1 <<< (SH - 1))) >>> SH;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[OUT_WIDTH-1:0];
   endfunction

   // Sum, round and saturate.
   logic [4*OUT_WIDTH-1:0] q_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff <= {finish(34'(p_ff[6]) + 34'(p_ff[7])),
                  finish(34'(p_ff[4]) - 34'(p_ff[5])),
                  finish(34'(p_ff[2]) + 34'(p_ff[3])),
                  finish(34'(p_ff[0]) - 34'(p_ff[1]))};
      end
   end

   // Output register.
   logic [4*OUT_WIDTH-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (advance) out_ff <= q_ff;
   end

   assign rsp.valid = vld_ff[NSTAGE-1];
   assign rsp.data = out_ff;
endmodule

FILE: src/e2q_checker.sv
// Port checker for the Euler-to-quaternion block, bound to the top level.
`timescale 1ns / 1ps
module e2q_checker #(
   parameter int DATA_WIDTH = 64
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_data
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled word changed.");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input blocked with empty output.");
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Input taken during stall.");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Output valid after reset.");
endmodule

bind euler_to_quaternion e2q_checker #(.DATA_WIDTH(4 * (OUT_FRAC_BITS + 2))) u_e2q_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

FILE: dv/tb_top.sv
// Testbench for euler_to_quaternion: random and directed angles checked against a bit-true model.
`timescale 1ns / 1ps
module tb_top;
   import e2q_pkg::*;

   localparam int OFB = 14;
   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 7;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   e2q_if #(.WIDTH(48)) req_if (clock);
   e2q_if #(.WIDTH(64)) rsp_if (clock);

   euler_to_quaternion #(.ANGLE_WIDTH(16), .OUT_FRAC_BITS(OFB), .TRIG_STAGES(STAGES)) uut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   quat_type expected_quats[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   bit hold_rsp = 1'b0;
   bit long_idle = 1'b1;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp(longint v, longint one);
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   task automatic half_trig(input logic [15:0] raw, output longint c, output longint s);
      longint h, x, y, z, dx, dy, t, one;
      int quad;
      one = 64'sd1 <<< 30;
      h = longint'($signed(raw)) % TURN_UNITS;
      if (h < 0) h += TURN_UNITS;
      quad = int'(h / QUARTER_UNITS);
      h -= longint'(quad) * QUARTER_UNITS;
      if (h >= EIGHTH_UNITS) begin
         h -= QUARTER_UNITS;
         quad = (quad + 1) & 3;
      end
      z = h * ANGLE_TO_ACC;
      x = INV_GAIN;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_deg(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_deg(i));
         end
      end
      x = clamp(x, one);
      y = clamp(y, one);
      case (quad)
         1: begin t = x; x = -y; y = t; end
         2: begin x = -x; y = -y; end
         3: begin t = x; x = y; y = -t; end
         default: ;
      endcase
      c = x;
      s = y;
   endtask

   function automatic logic [15:0] to_q14(longint t);
      longint r;
      r = floor_shift(t + (64'sd1 <<< (30 - OFB - 1)), 30 - OFB);
      return 16'(clamp(r, 64'sd1 <<< OFB));
   endfunction

   task automatic predict_quat(input logic [47:0] word, output quat_type q);
      longint cx, sx, cy, sy, cz, sz, cxcy, sxsy, sxcy, cxsy;
      half_trig(word[15:0], cx, sx);
      half_trig(word[31:16], cy, sy);
      half_trig(word[47:32], cz, sz);
      cxcy = qmul(cx, cy);
      sxsy = qmul(sx, sy);
      sxcy = qmul(sx, cy);
      cxsy = qmul(cx, sy);
      q.x = to_q14(qmul(sxcy, cz) - qmul(cxsy, sz));
      q.y = to_q14(qmul(cxsy, cz) + qmul(sxcy, sz));
      q.z = to_q14(qmul(cxcy, sz) - qmul(sxsy, cz));
      q.w = to_q14(qmul(cxcy, cz) + qmul(sxsy, sz));
   endtask

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      errors++;
      $display("Mismatch in %s at word %0d: got %0d, expected %0d", what, words_checked,
               $signed(got), $signed(want));
   endtask

   function automatic int gap_length();
      if (!long_idle) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az);
      int gap;
      quat_type q;
      gap = gap_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= {az, ay, ax};
      predict_quat({az, ay, ax}, q);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_quats.push_back(q);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_angle();
      case ($urandom_range(0, 5))
         0: return 16'h8000 + 16'($urandom_range(0, 3));
         1: return 16'h7fff - 16'($urandom_range(0, 3));
         2: return 16'($signed(32'($urandom_range(0, 16)) - 8));
         3: return 16'(32'd5760 * $urandom_range(0, 5) + $urandom_range(0, 2) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [15:0] edges[12];
      edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'd5760, 16'd5759,
                16'd11520, 16'd23040, -16'sd5760, -16'sd11520, 16'h5555};
      foreach (edges[i]) send_angles(edges[i], edges[(i + 4) % 12], edges[(i + 7) % 12]);
      send_angles(16'h7fff, 16'h7fff, 16'h7fff);
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'd11520, 16'd11520, 16'd11520);
      send_angles(16'hffff, 16'h0000, 16'h7fff);
      send_angles(16'haaaa, 16'h5555, 16'hffff);
      send_angles(16'h0000, 16'h0000, 16'h0000);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_angles(random_angle(), random_angle(), random_angle());
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      long_idle = 1'b0;
      test_random(60);
      long_idle = 1'b1;
   endtask

   task automatic test_back_to_back();
      long_idle = 1'b0;
      test_random(200);
      long_idle = 1'b1;
   endtask

   // The receiver stalls at random, and stops for a long stretch on request.
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      quat_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (expected_quats.size() == 0) begin
            errors++;
            $display("Unexpected quaternion word %h", got);
         end else begin
            want = expected_quats.pop_front();
            if (got.x !== want.x) report("quat_x", got.x, want.x);
            if (got.y !== want.y) report("quat_y", got.y, want.y);
            if (got.z !== want.z) report("quat_z", got.z, want.z);
            if (got.w !== want.w) report("quat_w", got.w, want.w);
         end
         words_checked++;
      end
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d words outstanding", expected_quats.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(450);
      test_backpressure();
      test_back_to_back();
      test_random(350);
      req_if.valid <= 1'b0;
      while (expected_quats.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      $display("Converted %0d angle triples and checked %0d quaternions,", words_sent,
               words_checked);
      $display("covering angle extremes, octant boundaries, stalls and a full pipeline.");
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

FILE: sim.f
src/e2q_pkg.sv
src/e2q_if.sv
src/e2q_cell.sv
src/euler_to_quaternion.sv
src/e2q_checker.sv
dv/tb_top.sv
